// ----- rtl/core/itp_pkg.sv -----
// itp_pkg: shared types, character and operator codes, and lookup functions
// for the infix-to-postfix converter. No dependencies.
package itp_pkg;

    // ascii characters the converter recognizes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_NONE   = 8'h00;

    // stack entry codes
    localparam logic [2:0] CODE_LPAREN = 3'd0;
    localparam logic [2:0] CODE_EQ     = 3'd1;
    localparam logic [2:0] CODE_PLUS   = 3'd2;
    localparam logic [2:0] CODE_MINUS  = 3'd3;
    localparam logic [2:0] CODE_MUL    = 3'd4;
    localparam logic [2:0] CODE_DIV    = 3'd5;
    localparam logic [2:0] CODE_POW    = 3'd6;

    // precedence levels
    localparam logic [2:0] PREC_NONE = 3'd0;
    localparam logic [2:0] PREC_EQ   = 3'd1;
    localparam logic [2:0] PREC_ADD  = 3'd2;
    localparam logic [2:0] PREC_MUL  = 3'd3;
    localparam logic [2:0] PREC_POW  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_TEST,
        S_PUSH,
        S_END,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        MODE_CLOSE,
        MODE_OP,
        MODE_FLUSH
    } t_mode;

    // request from the sequencer to the result stage
    typedef struct packed {
        logic       push;  // one more output character
        logic       fin;   // item done, close with last
        logic [7:0] ch;
        logic       eox;
        logic       ovf;
    } t_emit_req;

    // code and valid flag of an operator or '(' character
    typedef struct packed {
        logic       vld;
        logic [2:0] code;
    } t_code;

    function automatic t_code char_code(input logic [7:0] c);
        t_code r;
        r.vld  = 1'b1;
        r.code = CODE_LPAREN;
        unique case (c)
            CH_LPAREN: r.code = CODE_LPAREN;
            CH_EQ:     r.code = CODE_EQ;
            CH_PLUS:   r.code = CODE_PLUS;
            CH_MINUS:  r.code = CODE_MINUS;
            CH_MUL:    r.code = CODE_MUL;
            CH_DIV:    r.code = CODE_DIV;
            CH_POW:    r.code = CODE_POW;
            default:   r.vld  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] r;
        unique case (code)
            CODE_LPAREN: r = CH_LPAREN;
            CODE_EQ:     r = CH_EQ;
            CODE_PLUS:   r = CH_PLUS;
            CODE_MINUS:  r = CH_MINUS;
            CODE_MUL:    r = CH_MUL;
            CODE_DIV:    r = CH_DIV;
            CODE_POW:    r = CH_POW;
            default:     r = CH_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] code_prec(input logic [2:0] code);
        logic [2:0] r;
        unique case (code)
            CODE_EQ:               r = PREC_EQ;
            CODE_PLUS, CODE_MINUS: r = PREC_ADD;
            CODE_MUL, CODE_DIV:    r = PREC_MUL;
            CODE_POW:              r = PREC_POW;
            default:               r = PREC_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_left(input logic [2:0] code);
        return (code == CODE_PLUS) || (code == CODE_MINUS) ||
               (code == CODE_MUL) || (code == CODE_DIV);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
               (c >= CH_LA && c <= CH_LZ);
    endfunction

endpackage

// ----- rtl/core/itp_stack.sv -----
// itp_stack: operator stack storage, one write port and one registered read port.
// Depends on nothing; contents are not cleared by reset.
module itp_stack #(
    parameter int STACK_DEPTH = 32,
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [2:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [2:0]    o_rdata
);

    logic [2:0] mem [STACK_DEPTH];
    logic [2:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/itp_emit.sv -----
// itp_emit: result stage with one held character and an output register,
// so the last result of an item can be flagged. Depends on itp_pkg.
module itp_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itp_pkg::t_emit_req   i_req,
    output logic                 o_ready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [7:0]           o_symbol,
    output logic                 o_has,
    output logic                 o_eop,
    output logic                 o_ovf,
    output logic                 o_last
);

    logic       r_hold_v;
    logic [7:0] r_hold_ch;
    logic       r_ov;
    logic [7:0] r_sym;
    logic       r_has;
    logic       r_eop;
    logic       r_ovf;
    logic       r_last;
    logic       w_free;

    assign w_free  = !r_ov || i_m_tready;
    assign o_ready = w_free;

    // control: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else if (w_free && i_req.push) begin
            r_hold_v <= 1'b1;
            r_ov     <= r_hold_v;
        end else if (w_free && i_req.fin) begin
            r_hold_v <= 1'b0;
            r_ov     <= r_hold_v || i_req.eox || i_req.ovf;
        end else if (w_free) begin
            r_ov <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_free && i_req.push) begin
            r_hold_ch <= i_req.ch;
            r_sym     <= r_hold_ch;
            r_has     <= 1'b1;
            r_eop     <= 1'b0;
            r_ovf     <= 1'b0;
            r_last    <= 1'b0;
        end else if (w_free && i_req.fin) begin
            r_sym  <= r_hold_v ? r_hold_ch : itp_pkg::CH_NONE;
            r_has  <= r_hold_v;
            r_eop  <= i_req.eox;
            r_ovf  <= i_req.ovf;
            r_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_symbol   = r_sym;
    assign o_has      = r_has;
    assign o_eop      = r_eop;
    assign o_ovf      = r_ovf;
    assign o_last     = r_last;

endmodule

// ----- rtl/core/itp_seq.sv -----
// itp_seq: sequencer that walks the operator stack one entry per step, using a
// single precedence compare unit. Depends on itp_pkg.
module itp_seq #(
    parameter int STACK_DEPTH = 32,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_symbol,
    input  logic                 i_eox,
    output itp_pkg::t_emit_req   o_req,
    input  logic                 i_emit_ready,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [2:0]           o_wdata,
    output logic [AW-1:0]        o_raddr,
    input  logic [2:0]           i_rdata
);

    itp_pkg::t_state r_state, n_state;
    itp_pkg::t_mode  r_mode, n_mode;
    logic [7:0]      r_sym;
    logic            r_eox;
    logic            r_ovf;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   w_cnt_m1;

    itp_pkg::t_code  w_code;
    logic            w_alnum;
    logic            w_close;
    logic            w_empty;
    logic            w_full;
    logic            w_top_lp;
    logic            w_prec_pop;
    logic            w_pop_emit;
    logic            w_pop;

    // classify the held character
    assign w_code  = itp_pkg::char_code(r_sym);
    assign w_alnum = itp_pkg::is_alnum(r_sym);
    assign w_close = (r_sym == itp_pkg::CH_RPAREN);
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count >= CW'(STACK_DEPTH));

    // shared compare unit: stacked operator against incoming one
    assign w_top_lp   = (i_rdata == itp_pkg::CODE_LPAREN);
    assign w_prec_pop = (itp_pkg::code_prec(i_rdata) > itp_pkg::code_prec(w_code.code)) ||
                        (itp_pkg::is_left(w_code.code) &&
                         itp_pkg::code_prec(i_rdata) == itp_pkg::code_prec(w_code.code));

    assign w_pop_emit = (r_state == itp_pkg::S_TEST) &&
                        (((r_mode == itp_pkg::MODE_CLOSE) && !w_top_lp) ||
                         ((r_mode == itp_pkg::MODE_OP) && w_prec_pop) ||
                         (r_mode == itp_pkg::MODE_FLUSH));
    assign w_pop = (w_pop_emit && i_emit_ready) ||
                   ((r_state == itp_pkg::S_TEST) && (r_mode == itp_pkg::MODE_CLOSE) &&
                    w_top_lp);

    // stack addressing
    assign w_cnt_m1 = r_count - CW'(1);
    assign o_raddr  = w_cnt_m1[AW-1:0];
    assign o_waddr  = r_count[AW-1:0];
    assign o_wdata  = w_code.code;

    // next state
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        unique case (r_state)
            itp_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = itp_pkg::S_DECODE;
                end
            end
            itp_pkg::S_DECODE: begin
                n_mode = w_close ? itp_pkg::MODE_CLOSE : itp_pkg::MODE_OP;
                priority if (w_alnum) begin
                    n_state = i_emit_ready ? itp_pkg::S_END : itp_pkg::S_DECODE;
                end else if (w_close) begin
                    n_state = itp_pkg::S_RD;
                end else if (w_code.vld && w_code.code == itp_pkg::CODE_LPAREN) begin
                    n_state = itp_pkg::S_PUSH;
                end else if (w_code.vld) begin
                    n_state = itp_pkg::S_RD;
                end else begin
                    n_state = itp_pkg::S_END;
                end
            end
            itp_pkg::S_END: begin
                if (r_eox && !w_empty) begin
                    n_mode  = itp_pkg::MODE_FLUSH;
                    n_state = itp_pkg::S_RD;
                end else begin
                    n_state = itp_pkg::S_FIN;
                end
            end
            itp_pkg::S_RD: begin
                if (!w_empty) begin
                    n_state = itp_pkg::S_TEST;
                end else begin
                    unique case (r_mode)
                        itp_pkg::MODE_CLOSE: n_state = itp_pkg::S_END;
                        itp_pkg::MODE_OP:    n_state = itp_pkg::S_PUSH;
                        default:             n_state = itp_pkg::S_FIN;
                    endcase
                end
            end
            itp_pkg::S_TEST: begin
                priority if (w_pop_emit) begin
                    n_state = i_emit_ready ? itp_pkg::S_RD : itp_pkg::S_TEST;
                end else if (r_mode == itp_pkg::MODE_CLOSE) begin
                    n_state = itp_pkg::S_END;
                end else begin
                    n_state = itp_pkg::S_PUSH;
                end
            end
            itp_pkg::S_PUSH: begin
                n_state = itp_pkg::S_END;
            end
            itp_pkg::S_FIN: begin
                if (i_emit_ready) begin
                    n_state = itp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = itp_pkg::S_IDLE;
            end
        endcase
    end

    // outputs per state
    always_comb begin
        o_ready   = (r_state == itp_pkg::S_IDLE);
        o_we      = (r_state == itp_pkg::S_PUSH) && !w_full;
        o_req     = '0;
        o_req.ch  = r_sym;
        o_req.eox = r_eox;
        o_req.ovf = r_ovf;
        unique case (r_state)
            itp_pkg::S_DECODE: o_req.push = w_alnum;
            itp_pkg::S_TEST: begin
                o_req.push = w_pop_emit;
                o_req.ch   = itp_pkg::code_char(i_rdata);
            end
            itp_pkg::S_FIN:    o_req.fin = 1'b1;
            default:           o_req.push = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itp_pkg::S_IDLE;
            r_mode  <= itp_pkg::MODE_OP;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            if (o_we) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop) begin
                r_count <= w_cnt_m1;
            end
            if (r_state == itp_pkg::S_IDLE) begin
                r_ovf <= 1'b0;
            end else if (r_state == itp_pkg::S_PUSH && w_full) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sym <= i_symbol;
            r_eox <= i_eox;
        end
    end

endmodule

// ----- rtl/core/infix_to_postfix_converter.sv -----
// infix_to_postfix_converter: shunting-yard conversion, one character per transaction.
// A letter or digit goes to the held character of the result stage, then to its output register.
// A new character is taken only in the idle state, once the last one is fully handled: its
// walk of the stack, every pop and any end-of-expression flush, plus any output stall.
// Reset: synchronous active-low, clears sequencer, stack count and result stage.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32,
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] symbol
    input  logic       i_s_axis_tlast,   // end_of_expr
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_symbol
    output logic [2:0] o_m_axis_tuser,   // [0] has_symbol, [1] end_of_postfix, [2] overflow
    output logic       o_m_axis_tlast    // last
);

    itp_pkg::t_emit_req w_req;
    logic               w_emit_ready;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [2:0]         w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [2:0]         w_rdata;

    // sequencer with shared precedence compare
    itp_seq #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_symbol     (i_s_axis_tdata),
        .i_eox        (i_s_axis_tlast),
        .o_req        (w_req),
        .i_emit_ready (w_emit_ready),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata)
    );

    // operator stack
    itp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // result stage
    itp_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_ready    (w_emit_ready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_symbol   (o_m_axis_tdata),
        .o_has      (o_m_axis_tuser[0]),
        .o_eop      (o_m_axis_tuser[1]),
        .o_ovf      (o_m_axis_tuser[2]),
        .o_last     (o_m_axis_tlast)
    );

endmodule

// ----- verif/postfix_checker.sv -----
`timescale 1ns / 1ps
// postfix_checker: watches both stream channels of the infix-to-postfix converter,
// predicts the postfix transactions and compares them field by field.
// Depends on itp_pkg for character and operator codes.
module postfix_checker
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] symbol
    input  logic       i_s_tlast,    // end_of_expr
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [7:0] out_symbol
    input  logic [2:0] i_m_tuser,    // [0] has_symbol, [1] end_of_postfix, [2] overflow
    input  logic       i_m_tlast,    // last
    output int         o_mismatch_count,
    output int         o_pending_count
);

    typedef struct packed {
        logic [7:0] sym;
        logic       has;
        logic       eop;
        logic       ovf;
        logic       lst;
    } t_postfix_res;

    // expected postfix transactions, oldest first
    t_postfix_res postfix_q[$];

    // shadow operator stack
    logic [2:0] op_stk [STACK_DEPTH];
    int         stk_cnt;
    int         item_emits;

    initial begin
        o_mismatch_count = 0;
        o_pending_count  = 0;
        stk_cnt          = 0;
    end

    // binding strength of a stacked operator, '(' binds weakest
    function automatic logic [2:0] prio_of(input logic [2:0] code);
        logic [2:0] p;
        case (code)
            CODE_EQ:               p = PREC_EQ;
            CODE_PLUS, CODE_MINUS: p = PREC_ADD;
            CODE_MUL, CODE_DIV:    p = PREC_MUL;
            CODE_POW:              p = PREC_POW;
            default:               p = PREC_NONE;
        endcase
        return p;
    endfunction

    // map an operator or '(' character to its stack code
    function automatic bit lookup_op(input logic [7:0] c, output logic [2:0] code);
        bit hit;
        hit  = 1'b1;
        code = CODE_LPAREN;
        case (c)
            CH_LPAREN: code = CODE_LPAREN;
            CH_EQ:     code = CODE_EQ;
            CH_PLUS:   code = CODE_PLUS;
            CH_MINUS:  code = CODE_MINUS;
            CH_MUL:    code = CODE_MUL;
            CH_DIV:    code = CODE_DIV;
            CH_POW:    code = CODE_POW;
            default:   hit  = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] op_char_of(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_LPAREN: c = CH_LPAREN;
            CODE_EQ:     c = CH_EQ;
            CODE_PLUS:   c = CH_PLUS;
            CODE_MINUS:  c = CH_MINUS;
            CODE_MUL:    c = CH_MUL;
            CODE_DIV:    c = CH_DIV;
            CODE_POW:    c = CH_POW;
            default:     c = CH_NONE;
        endcase
        return c;
    endfunction

    task automatic push_out(input logic [7:0] ch, input logic has);
        t_postfix_res r;
        r.sym = has ? ch : CH_NONE;
        r.has = has;
        r.eop = 1'b0;
        r.ovf = 1'b0;
        r.lst = 1'b0;
        postfix_q.push_back(r);
        item_emits++;
    endtask

    task automatic pop_out();
        stk_cnt--;
        push_out(op_char_of(op_stk[stk_cnt]), 1'b1);
    endtask

    // shunting-yard step for one accepted character
    task automatic predict_postfix(input logic [7:0] c, input logic eox);
        logic [2:0]   code;
        logic [2:0]   p;
        bit           is_op;
        bit           left_assoc;
        bit           ovf;
        t_postfix_res tail;
        ovf        = 1'b0;
        item_emits = 0;
        is_op      = lookup_op(c, code);
        if ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
            (c >= CH_LA && c <= CH_LZ)) begin
            push_out(c, 1'b1);
        end else if (c == CH_RPAREN) begin
            while (stk_cnt > 0 && op_stk[stk_cnt-1] != CODE_LPAREN)
                pop_out();
            // drop the matching '(' if there is one
            if (stk_cnt > 0)
                stk_cnt--;
        end else if (is_op) begin
            if (code != CODE_LPAREN) begin
                p          = prio_of(code);
                left_assoc = (code == CODE_PLUS) || (code == CODE_MINUS) ||
                             (code == CODE_MUL) || (code == CODE_DIV);
                while (stk_cnt > 0 && (prio_of(op_stk[stk_cnt-1]) > p ||
                       (left_assoc && prio_of(op_stk[stk_cnt-1]) == p)))
                    pop_out();
            end
            if (stk_cnt < STACK_DEPTH) begin
                op_stk[stk_cnt] = code;
                stk_cnt++;
            end else begin
                ovf = 1'b1;
            end
        end
        // end of expression empties the stack, unmatched '(' included
        if (eox) begin
            while (stk_cnt > 0)
                pop_out();
        end
        if ((eox || ovf) && item_emits == 0)
            push_out(CH_NONE, 1'b0);
        // flags ride on the final transaction of the item
        if (item_emits > 0) begin
            tail     = postfix_q.pop_back();
            tail.eop = eox;
            tail.ovf = ovf;
            tail.lst = 1'b1;
            postfix_q.push_back(tail);
        end
    endtask

    task automatic check_result();
        t_postfix_res want;
        t_postfix_res got;
        bit           bad;
        got.sym = i_m_tdata;
        got.has = i_m_tuser[0];
        got.eop = i_m_tuser[1];
        got.ovf = i_m_tuser[2];
        got.lst = i_m_tlast;
        if (postfix_q.size() == 0) begin
            if (o_mismatch_count < 10)
                $display("%0t: unexpected postfix transaction sym=%h has=%b eop=%b ovf=%b last=%b",
                         $realtime, got.sym, got.has, got.eop, got.ovf, got.lst);
            o_mismatch_count++;
        end else begin
            want = postfix_q.pop_front();
            bad  = (got.sym != want.sym) || (got.has != want.has) ||
                   (got.eop != want.eop) || (got.ovf != want.ovf) ||
                   (got.lst != want.lst);
            if (bad) begin
                if (o_mismatch_count < 10)
                    $display("%0t: postfix mismatch exp sym=%h has=%b eop=%b ovf=%b last=%b, got sym=%h has=%b eop=%b ovf=%b last=%b",
                             $realtime, want.sym, want.has, want.eop, want.ovf, want.lst,
                             got.sym, got.has, got.eop, got.ovf, got.lst);
                o_mismatch_count++;
            end
        end
    endtask

    // output transactions first, they always belong to earlier inputs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stk_cnt = 0;
            postfix_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                predict_postfix(i_s_tdata, i_s_tlast);
        end
        o_pending_count = postfix_q.size();
    end

endmodule

// ----- verif/tb_infix_to_postfix_converter.sv -----
`timescale 1ns / 1ps
// tb_infix_to_postfix_converter: drives character streams into the converter with
// bursty input and stalling output, and reports the verdict from postfix_checker.
// Depends on itp_pkg, infix_to_postfix_converter and postfix_checker.
module tb_infix_to_postfix_converter;
    import itp_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLDOFF_LEN  = 400;
    localparam int RANDOM_ITEMS = 150;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] symbol
    logic       i_s_axis_tlast;   // end_of_expr
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [7:0] out_symbol
    logic [2:0] o_m_axis_tuser;   // [0] has_symbol, [1] end_of_postfix, [2] overflow
    logic       o_m_axis_tlast;   // last

    int         mismatch_count;
    int         pending_count;
    int         n_sent;
    int         burst_left;
    int         idle_cycles;
    bit         holdoff_done;
    logic [7:0] expr_q[$];

    infix_to_postfix_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    postfix_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_axis_tvalid),
        .i_s_tready       (o_s_axis_tready),
        .i_s_tdata        (i_s_axis_tdata),
        .i_s_tlast        (i_s_axis_tlast),
        .i_m_tvalid       (o_m_axis_tvalid),
        .i_m_tready       (i_m_axis_tready),
        .i_m_tdata        (o_m_axis_tdata),
        .i_m_tuser        (o_m_axis_tuser),
        .i_m_tlast        (o_m_axis_tlast),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transaction
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: stall density changes per span, one long hold-off to back up the block
    initial begin
        int stall_pct;
        int span;
        i_m_axis_tready = 1'b0;
        holdoff_done    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 90;
            endcase
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge i_clk);
                if (!holdoff_done && n_sent >= 40) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (HOLDOFF_LEN) @(negedge i_clk);
                    holdoff_done = 1'b1;
                end
                i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // one input transaction, sender works in bursts with gaps between them
    task automatic send_char(input logic [7:0] sym, input logic eox);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= sym;
        i_s_axis_tlast  <= eox;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
        n_sent++;
    endtask

    function automatic logic [7:0] rand_operand();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0:       c = CH_0 + 8'($urandom_range(0, 9));
            1:       c = CH_UA + 8'($urandom_range(0, 25));
            default: c = CH_LA + 8'($urandom_range(0, 25));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_operator();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = CH_PLUS;
            1:       c = CH_MINUS;
            2:       c = CH_MUL;
            3:       c = CH_DIV;
            4:       c = CH_POW;
            default: c = CH_EQ;
        endcase
        return c;
    endfunction

    // well-formed expression with random operands, operators and nesting
    task automatic send_expr();
        int n_terms;
        int opens;
        expr_q.delete();
        n_terms = $urandom_range(1, 6);
        opens   = 0;
        for (int t = 0; t < n_terms; t++) begin
            if (t < n_terms - 1 && opens < 4 && $urandom_range(0, 3) == 0) begin
                expr_q.push_back(CH_LPAREN);
                opens++;
            end
            expr_q.push_back(rand_operand());
            if (opens > 0 && $urandom_range(0, 2) == 0) begin
                expr_q.push_back(CH_RPAREN);
                opens--;
            end
            if (t < n_terms - 1)
                expr_q.push_back(rand_operator());
        end
        while (opens > 0) begin
            expr_q.push_back(CH_RPAREN);
            opens--;
        end
        foreach (expr_q[i])
            send_char(expr_q[i], i == expr_q.size() - 1);
    endtask

    // nesting and right-associative chains that never pop, driving the stack past full
    task automatic send_deep();
        int n_push;
        n_push = $urandom_range(33, 38);
        for (int i = 0; i < n_push; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_char(CH_LPAREN, 1'b0);
            end else begin
                send_char(rand_operand(), 1'b0);
                send_char(CH_POW, 1'b0);
            end
        end
        if ($urandom_range(0, 1) == 0)
            send_char(CH_RPAREN, 1'b0);
        send_char(rand_operand(), 1'b1);
    endtask

    // arbitrary bytes and stray operators with random end flags
    task automatic send_noise();
        int         len;
        logic [7:0] c;
        len = $urandom_range(3, 10);
        repeat (len) begin
            case ($urandom_range(0, 3))
                0, 1:    c = 8'($urandom_range(0, 255));
                2:       c = ($urandom_range(0, 1) == 0) ? CH_LPAREN : CH_RPAREN;
                default: c = rand_operator();
            endcase
            send_char(c, $urandom_range(0, 7) == 0);
        end
    endtask

    // main stimulus and verdict
    initial begin
        int seq_idx;
        int n_directed;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        n_sent          = 0;
        burst_left      = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-stack close, bare end marker, every operator, extremes
        send_char(CH_RPAREN, 1'b0);
        send_char(CH_NONE, 1'b1);
        send_char("a", 1'b0);
        send_char(CH_EQ, 1'b0);
        send_char("b", 1'b0);
        send_char(CH_EQ, 1'b0);
        send_char(CH_LPAREN, 1'b0);
        send_char("c", 1'b0);
        send_char(CH_POW, 1'b0);
        send_char("d", 1'b0);
        send_char(CH_POW, 1'b0);
        send_char(CH_0, 1'b0);
        send_char(CH_RPAREN, 1'b0);
        send_char(CH_PLUS, 1'b0);
        send_char(CH_UZ, 1'b0);
        send_char(CH_MINUS, 1'b0);
        send_char(CH_LZ, 1'b0);
        send_char(CH_MUL, 1'b0);
        send_char(CH_UA, 1'b0);
        send_char(CH_DIV, 1'b0);
        send_char(CH_9, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(" ", 1'b0);
        send_char(CH_LPAREN, 1'b1);
        n_directed = n_sent;

        // random: mostly well-formed expressions, some overflow runs and noise
        seq_idx = 0;
        while (n_sent - n_directed < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       send_deep();
                1, 2:    send_noise();
                default: begin
                    if (seq_idx == 1)
                        send_deep();
                    else
                        send_expr();
                end
            endcase
            seq_idx++;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        // drain, then let any trailing work settle
        while (pending_count != 0) @(negedge i_clk);
        repeat (64) @(negedge i_clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
